// File: rtl/qpd_pkg.sv
// Package: shared types, codes, constants and the step table for the quadrature drive unit.
package qpd_pkg;

    // Position counter width (16..32); the reported position is sign-extended to 32 bits.
    localparam int POSITION_WIDTH = 32;

    // Input op codes
    localparam logic [1:0] OP_EDGE      = 2'd0;
    localparam logic [1:0] OP_RECOMPUTE = 2'd1;
    localparam logic [1:0] OP_SYNC      = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DRIVE_ENABLE = 2'd0;
    localparam logic [1:0] CFG_MIN_DUTY     = 2'd1;
    localparam logic [1:0] CFG_PWM_PERIOD   = 2'd2;

    // Configuration reset values
    localparam logic [6:0]  MIN_DUTY_RESET = 7'd20;
    localparam logic [15:0] PERIOD_RESET   = 16'd5000;

    // Drive math constants
    localparam logic signed [32:0] SAT_DISTANCE = 33'sd1000;
    localparam logic [6:0]         PCT_MAX      = 7'd100;
    localparam int                 SQ_SHIFT     = 7;
    localparam logic [19:0]        SQ_ROUND     = 20'd127;
    // ceil(2^30 / 100): exact quotient for products below 2^23
    localparam logic [23:0]        RECIP_100    = 24'd10737419;
    localparam int                 RECIP_SHIFT  = 30;

    // Classified item kind
    typedef enum logic [1:0] {
        KIND_EDGE,
        KIND_RECOMPUTE,
        KIND_SYNC,
        KIND_NOP
    } kind_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_SQUARE,
        ST_SCALE,
        ST_MULT,
        ST_EMIT
    } state_t;

    // One classified command in the queue
    typedef struct packed {
        kind_t              kind;
        logic               compute;
        logic [1:0]         now;
        logic signed [31:0] target;
    } cmd_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    // Configuration registers
    typedef struct packed {
        logic        drive_enable;
        logic [6:0]  min_duty;
        logic [15:0] period;
    } cfg_t;

    // One result transaction
    typedef struct packed {
        logic [31:0] position;
        logic [31:0] edge_count;
        logic        duty_written;
        logic        dir_forward;
        logic        dir_reverse;
        logic [15:0] duty_ticks;
        logic [7:0]  drive_percent;
    } result_t;

    // Gray transition table, index {old phase, new phase}
    localparam logic signed [1:0] STEP_TABLE [16] = '{
         2'sd0,  2'sd1, -2'sd1,  2'sd0,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
         2'sd0, -2'sd1,  2'sd1,  2'sd0
    };

    function automatic logic signed [1:0] step_delta(input logic [1:0] old_phase,
                                                     input logic [1:0] new_phase);
        return STEP_TABLE[{old_phase, new_phase}];
    endfunction

endpackage

// File: rtl/qpd_front.sv
// Front end: accepts input transactions, classifies them and queues them in a two-entry command queue.
module qpd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_op,
    input  logic [1:0]         in_now,
    input  logic signed [31:0] in_target,
    input  logic               drive_enable,
    output qpd_pkg::q_head_t   head,
    input  logic               pop
);

    qpd_pkg::cmd_t q_mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    qpd_pkg::cmd_t cmd_in;
    logic          push;

    // Classify the incoming op
    always_comb
    begin
        cmd_in.now    = in_now;
        cmd_in.target = in_target;
        unique case (in_op)
            qpd_pkg::OP_EDGE:      cmd_in.kind = qpd_pkg::KIND_EDGE;
            qpd_pkg::OP_RECOMPUTE: cmd_in.kind = qpd_pkg::KIND_RECOMPUTE;
            qpd_pkg::OP_SYNC:      cmd_in.kind = qpd_pkg::KIND_SYNC;
            default:               cmd_in.kind = qpd_pkg::KIND_NOP;
        endcase
        cmd_in.compute = drive_enable &&
                         (cmd_in.kind == qpd_pkg::KIND_EDGE ||
                          cmd_in.kind == qpd_pkg::KIND_RECOMPUTE);
    end

    assign in_ready   = (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = q_mem_reg[rd_ptr_reg];

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: rtl/qpd_back.sv
// Back end: updates the encoder state, runs the drive math and holds the result register.
module qpd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  qpd_pkg::q_head_t  head,
    output logic              pop,
    input  qpd_pkg::cfg_t     cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output qpd_pkg::result_t  result
);

    localparam int PW = qpd_pkg::POSITION_WIDTH;

    qpd_pkg::state_t state_reg, state_next;

    // Encoder state
    logic [1:0]    phase_reg;
    logic [PW-1:0] pos_reg;
    logic [31:0]   count_reg;

    // Drive math pipeline registers
    logic                compute_reg;
    logic signed [31:0]  target_reg;
    logic signed [32:0]  dist_reg;
    logic                neg_reg;
    logic                sat_reg;
    logic [19:0]         sq_reg;
    logic [6:0]          pmag_reg;
    logic                write_reg;
    logic [7:0]          pct_reg;
    logic [22:0]         prod_reg;

    logic                out_valid_reg, out_valid_next;
    qpd_pkg::result_t    result_reg;

    logic                emit;
    logic                out_free;

    // Combinational datapath pieces
    logic signed [1:0]   delta;
    logic signed [32:0]  dist_next;
    logic [10:0]         mag11;
    logic [9:0]          mag10;
    logic [19:0]         sq_next;
    logic [12:0]         shf;
    logic [6:0]          cmag;
    logic [6:0]          lmag;
    logic [46:0]         scaled;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qpd_pkg::ST_IDLE:
                if (head.valid)
                begin
                    state_next = head.cmd.compute ? qpd_pkg::ST_DIST : qpd_pkg::ST_EMIT;
                end
            qpd_pkg::ST_DIST:   state_next = qpd_pkg::ST_SQUARE;
            qpd_pkg::ST_SQUARE: state_next = qpd_pkg::ST_SCALE;
            qpd_pkg::ST_SCALE:  state_next = qpd_pkg::ST_MULT;
            qpd_pkg::ST_MULT:   state_next = qpd_pkg::ST_EMIT;
            qpd_pkg::ST_EMIT:
                if (out_free)
                begin
                    state_next = qpd_pkg::ST_IDLE;
                end
            default:            state_next = qpd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        unique case (state_reg)
            qpd_pkg::ST_IDLE: pop  = head.valid;
            qpd_pkg::ST_EMIT: emit = out_free;
            default:
            begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    // Datapath arithmetic
    always_comb
    begin
        delta     = qpd_pkg::step_delta(phase_reg, head.cmd.now);
        dist_next = 33'(target_reg) - 33'(signed'(pos_reg));
        mag11     = dist_reg[32] ? (11'd0 - dist_reg[10:0]) : dist_reg[10:0];
        mag10     = mag11[9:0];
        sq_next   = {10'd0, mag10} * {10'd0, mag10};
        shf       = neg_reg ? 13'((sq_reg + qpd_pkg::SQ_ROUND) >> qpd_pkg::SQ_SHIFT)
                            : 13'(sq_reg >> qpd_pkg::SQ_SHIFT);
        cmag      = (sat_reg || shf > 13'(qpd_pkg::PCT_MAX)) ? qpd_pkg::PCT_MAX : shf[6:0];
        lmag      = (cmag != 7'd0 && cmag < cfg.min_duty) ? cfg.min_duty : cmag;
        scaled    = {24'd0, prod_reg} * {23'd0, qpd_pkg::RECIP_100};
    end

    // Encoder state update on pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            pos_reg   <= '0;
            count_reg <= 32'd0;
        end
        else if (pop)
        begin
            unique case (head.cmd.kind) inside
                qpd_pkg::KIND_EDGE:
                begin
                    phase_reg <= head.cmd.now;
                    pos_reg   <= pos_reg + PW'(delta);
                    count_reg <= count_reg + 32'd1;
                end
                qpd_pkg::KIND_SYNC:
                begin
                    phase_reg <= head.cmd.now;
                    pos_reg   <= '0;
                    count_reg <= 32'd0;
                end
                qpd_pkg::KIND_RECOMPUTE, qpd_pkg::KIND_NOP:
                begin
                    phase_reg <= phase_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qpd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            compute_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                compute_reg <= head.cmd.compute;
            end
        end
    end

    always_comb
    begin
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Drive math stages
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            target_reg <= head.cmd.target;
        end
        if (state_reg == qpd_pkg::ST_DIST)
        begin
            dist_reg <= dist_next;
        end
        if (state_reg == qpd_pkg::ST_SQUARE)
        begin
            sq_reg  <= sq_next;
            neg_reg <= dist_reg[32];
            sat_reg <= (dist_reg > qpd_pkg::SAT_DISTANCE) ||
                       (dist_reg < -qpd_pkg::SAT_DISTANCE);
        end
        if (state_reg == qpd_pkg::ST_SCALE)
        begin
            pmag_reg  <= lmag;
            write_reg <= (lmag <= qpd_pkg::PCT_MAX);
            pct_reg   <= neg_reg ? (8'd0 - {1'b0, lmag}) : {1'b0, lmag};
        end
        if (state_reg == qpd_pkg::ST_MULT)
        begin
            prod_reg <= 23'({7'd0, cfg.period} * {16'd0, pmag_reg});
        end
        if (emit)
        begin
            result_reg.position      <= 32'(signed'(pos_reg));
            result_reg.edge_count    <= count_reg;
            result_reg.duty_written  <= compute_reg && write_reg;
            result_reg.dir_forward   <= compute_reg && write_reg && !pct_reg[7];
            result_reg.dir_reverse   <= compute_reg && write_reg && pct_reg[7];
            result_reg.duty_ticks    <= (compute_reg && write_reg)
                                        ? scaled[qpd_pkg::RECIP_SHIFT+15:qpd_pkg::RECIP_SHIFT]
                                        : 16'd0;
            result_reg.drive_percent <= compute_reg ? pct_reg : 8'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// File: rtl/quadrature_position_pwm_drive_unit.sv
// Top level: quadrature position counter with proportional PWM drive command output.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: encoder levels, target; tuser: op
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: position, count, duty; tuser: written
//  cfg       in   cfg_we                         cfg_index, cfg_data
//
// An item that computes a drive passes through the back-end sequencer states (pop/state
// update, distance, square, clamp and lift, period multiply, reciprocal multiply);
// edges with drive off, syncs and unused ops go from the pop straight to the emit state.
// A two-entry command queue lets input transactions land while the back end is busy.
// The result register holds a stalled result; the back end may pop the next command
// meanwhile. Reset is asynchronous: configuration returns to defaults, state clears.
module quadrature_position_pwm_drive_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // sensor_a, sensor_b, target_position[31:0], zero pad
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // position, edge_count, dir_forward, dir_reverse,
                                        // duty_ticks, drive_percent, zero pad
    output logic        m_axis_tuser,   // duty_written
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    qpd_pkg::cfg_t    cfg_reg;
    qpd_pkg::q_head_t q_head;
    logic             q_pop;
    qpd_pkg::result_t result;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_enable <= 1'b0;
            cfg_reg.min_duty     <= qpd_pkg::MIN_DUTY_RESET;
            cfg_reg.period       <= qpd_pkg::PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qpd_pkg::CFG_DRIVE_ENABLE: cfg_reg.drive_enable <= cfg_data[0];
                qpd_pkg::CFG_MIN_DUTY:     cfg_reg.min_duty     <= cfg_data[6:0];
                qpd_pkg::CFG_PWM_PERIOD:   cfg_reg.period       <= cfg_data;
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    qpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_op        (s_axis_tuser),
        .in_now       (s_axis_tdata[1:0]),
        .in_target    (signed'(s_axis_tdata[33:2])),
        .drive_enable (cfg_reg.drive_enable),
        .head         (q_head),
        .pop          (q_pop)
    );

    qpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .pop       (q_pop),
        .cfg       (cfg_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    // Output packing
    assign m_axis_tdata = {6'd0,
                           result.drive_percent,
                           result.duty_ticks,
                           result.dir_reverse,
                           result.dir_forward,
                           result.edge_count,
                           result.position};
    assign m_axis_tuser = result.duty_written;

`ifndef SYNTHESIS
    // The back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("command popped from empty queue");

    // A written duty command carries exactly one direction bit
    a_dir_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> $onehot(m_axis_tdata[65:64]))
        else $error("duty command without a single direction bit");

    // No duty command means no direction and no on-time
    a_no_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
            (m_axis_tdata[65:64] == 2'd0 && m_axis_tdata[81:66] == 16'd0))
        else $error("direction or duty set without a duty command");
`endif

endmodule

// File: tb/sv/quadrature_position_pwm_drive_unit_test.sv
// Self-checking testbench for the quadrature position counter with PWM drive output.
`timescale 1ns / 100ps

module quadrature_position_pwm_drive_unit_test;

    // Op code 3 is not decoded by the block; it must report state unchanged
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 230;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int POS_W = qpd_pkg::POSITION_WIDTH;

    // One directed stimulus row; want is only used when typed is set
    typedef struct packed {
        logic             load_cfg;
        qpd_pkg::cfg_t    cfg;
        logic [1:0]       op;
        logic [1:0]       levels;    // {sensor_b, sensor_a}
        logic [31:0]      target;
        logic             typed;
        qpd_pkg::result_t want;
    } dir_row_t;

    localparam int N_DIRECTED = 26;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // reset defaults, drive off: counting through the Gray sequence
        '{1'b0, '0, qpd_pkg::OP_SYNC, 2'b00, 32'd0, 1'b1,
          '{32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0}},
        '{1'b0, '0, qpd_pkg::OP_EDGE, 2'b01, 32'd0, 1'b1,
          '{32'd1, 32'd1, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0}},
        '{1'b0, '0, qpd_pkg::OP_EDGE, 2'b11, 32'd0, 1'b0, '0},
        '{1'b0, '0, qpd_pkg::OP_EDGE, 2'b10, 32'd0, 1'b0, '0},
        '{1'b0, '0, qpd_pkg::OP_EDGE, 2'b11, 32'd0, 1'b0, '0},      // backward step
        '{1'b0, '0, qpd_pkg::OP_EDGE, 2'b11, 32'd0, 1'b0, '0},      // unchanged phase
        '{1'b0, '0, qpd_pkg::OP_EDGE, 2'b00, 32'd0, 1'b0, '0},      // illegal jump
        '{1'b0, '0, OP_UNUSED, 2'b11, 32'hFFFF_FFFF, 1'b1,
          '{32'd2, 32'd6, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0}},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'd1000, 1'b0, '0},
        // drive on with default lift and period
        '{1'b1, '{1'b1, 7'd20, 16'd5000}, qpd_pkg::OP_SYNC, 2'b00, 32'd0, 1'b0, '0},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'd0, 1'b1,
          '{32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 16'd0, 8'd0}},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'h7FFF_FFFF, 1'b1,
          '{32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 16'd5000, 8'd100}},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'h8000_0000, 1'b1,
          '{32'd0, 32'd0, 1'b1, 1'b0, 1'b1, 16'd5000, 8'h9C}},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'd5, 1'b0, '0},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'd12, 1'b0, '0},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, -32'sd12, 1'b0, '0},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'd113, 1'b0, '0},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, -32'sd1001, 1'b0, '0},
        '{1'b0, '0, qpd_pkg::OP_EDGE, 2'b01, 32'd100, 1'b0, '0},
        // lift above 100: percent reported, no command
        '{1'b1, '{1'b1, 7'd127, 16'd0}, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'd13, 1'b1,
          '{32'd1, 32'd1, 1'b0, 1'b0, 1'b0, 16'd0, 8'h7F}},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, -32'sd11, 1'b0, '0},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'd1, 1'b0, '0},
        // widest period, no lift
        '{1'b1, '{1'b1, 7'd0, 16'd65535}, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'h7FFF_FFFF, 1'b1,
          '{32'd1, 32'd1, 1'b1, 1'b1, 1'b0, 16'd65535, 8'd100}},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'd13, 1'b0, '0},
        // smallest period, full lift
        '{1'b1, '{1'b1, 7'd100, 16'd1}, qpd_pkg::OP_RECOMPUTE, 2'b00, 32'd3, 1'b0, '0},
        '{1'b0, '0, qpd_pkg::OP_RECOMPUTE, 2'b00, -32'sd1, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Predictor state and its copy of the registers
    logic [1:0]  enc_phase;
    logic [63:0] pos_acc;
    logic [31:0] edge_total;
    logic        drive_on;
    logic [6:0]  lift_pct;
    logic [15:0] period_ticks;

    qpd_pkg::result_t drive_reports_due [$];
    int               mismatch_count = 0;
    int               send_idle = 0;
    int               stall_pct = 0;
    int               hold_req = 0;
    int               hold_left = 0;

    quadrature_position_pwm_drive_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Position counter seen as a signed value of POS_W bits
    function automatic longint signed_position();
        logic [63:0] v;
        v = pos_acc & ((64'd1 << POS_W) - 64'd1);
        if (v[POS_W-1])
            return longint'(v) - (longint'(1) << POS_W);
        return longint'(v);
    endfunction

    // Gray code to binary: order along the sequence 0,1,3,2
    function automatic logic [1:0] gray_rank(input logic [1:0] ph);
        return {ph[1], ph[1] ^ ph[0]};
    endfunction

    // Squared distance law with saturation, then lift to the minimum magnitude
    function automatic int drive_pct(input longint distance);
        longint mag;
        longint sq;
        longint s;
        int     p;
        int     m;
        if (distance > 1000)
            p = 100;
        else if (distance < -1000)
            p = -100;
        else
        begin
            mag = (distance < 0) ? -distance : distance;
            sq  = mag * mag;
            s   = (distance >= 0) ? (sq >> 7) : -((sq + 127) >> 7);
            if (s > 100)
                s = 100;
            if (s < -100)
                s = -100;
            p = int'(s);
        end
        m = int'(lift_pct);
        if (p < 0 && p > -m)
            p = -m;
        else if (p > 0 && p < m)
            p = m;
        return p;
    endfunction

    // Apply one transaction to the predictor state and return the expected report
    function automatic qpd_pkg::result_t advance_encoder(input logic [1:0] op,
                                                         input logic [1:0] lv,
                                                         input logic [31:0] target);
        qpd_pkg::result_t r;
        logic             run_drive;
        logic [1:0]       d;
        int               p;
        int               mag;
        r = '0;
        run_drive = 1'b0;
        case (op)
            qpd_pkg::OP_EDGE:
            begin
                d = gray_rank(lv) - gray_rank(enc_phase);
                if (d == 2'd1)
                    pos_acc = (pos_acc + 64'd1) & ((64'd1 << POS_W) - 64'd1);
                else if (d == 2'd3)
                    pos_acc = (pos_acc - 64'd1) & ((64'd1 << POS_W) - 64'd1);
                enc_phase  = lv;
                edge_total = edge_total + 32'd1;
                run_drive  = drive_on;
            end
            qpd_pkg::OP_RECOMPUTE:
                run_drive = drive_on;
            qpd_pkg::OP_SYNC:
            begin
                enc_phase  = lv;
                pos_acc    = '0;
                edge_total = '0;
            end
            default: ;
        endcase
        if (run_drive)
        begin
            p = drive_pct(longint'($signed(target)) - signed_position());
            r.drive_percent = p[7:0];
            if (p >= -100 && p <= 100)
            begin
                mag = (p < 0) ? -p : p;
                r.duty_written = 1'b1;
                r.dir_reverse  = (p < 0);
                r.dir_forward  = (p >= 0);
                r.duty_ticks   = 16'((32'(period_ticks) * mag) / 100);
            end
        end
        r.position   = 32'(signed_position());
        r.edge_count = edge_total;
        return r;
    endfunction

    // Offer one input transaction, with random idle cycles ahead of it
    task automatic push_item(input logic [1:0] op, input logic [1:0] lv,
                             input logic [31:0] target);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, target, lv};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Write all three registers; unused upper data bits of the enable and lift writes carry noise
    task automatic load_registers(input logic en, input logic [6:0] lift,
                                  input logic [15:0] period);
        cfg_we    <= 1'b1;
        cfg_index <= qpd_pkg::CFG_DRIVE_ENABLE;
        cfg_data  <= {15'($urandom), en};
        @(posedge clk);
        cfg_index <= qpd_pkg::CFG_MIN_DUTY;
        cfg_data  <= {9'($urandom), lift};
        @(posedge clk);
        cfg_index <= qpd_pkg::CFG_PWM_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        cfg_we       <= 1'b0;
        drive_on     = en;
        lift_pct     = lift;
        period_ticks = period;
    endtask

    task automatic wait_reports_done();
        while (drive_reports_due.size() != 0)
            @(posedge clk);
    endtask

    // Mostly legal quadrature steps with targets near the position, plus noise
    task automatic random_item();
        logic [1:0]  op;
        logic [1:0]  lv;
        logic [1:0]  rank;
        logic [31:0] target;
        int          pick;
        pick = $urandom_range(0, 99);
        op   = qpd_pkg::OP_EDGE;
        lv   = 2'($urandom);
        if (pick < 55)
        begin
            rank = gray_rank(enc_phase) + ($urandom_range(0, 1) ? 2'd1 : 2'd3);
            lv   = {rank[1], rank[1] ^ rank[0]};
        end
        else if (pick < 65)
            op = qpd_pkg::OP_EDGE;
        else if (pick < 88)
            op = qpd_pkg::OP_RECOMPUTE;
        else if (pick < 96)
            op = qpd_pkg::OP_SYNC;
        else
            op = OP_UNUSED;
        if ($urandom_range(0, 4) == 0)
            target = $urandom;
        else
            target = 32'(signed_position() + longint'(int'($urandom_range(0, 2400)) - 1200));
        push_item(op, lv, target);
        drive_reports_due.push_back(advance_encoder(op, lv, target));
    endtask

    task automatic run_phase(input int idle_pct, input int stall, input logic en,
                             input logic [6:0] lift, input logic [15:0] period,
                             input int hold_at);
        send_idle = idle_pct;
        stall_pct = stall;
        load_registers(en, lift, period);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (n == hold_at)
                hold_req = HOLD_CYCLES;
            random_item();
        end
        s_axis_tvalid <= 1'b0;
        wait_reports_done();
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result side: check each accepted transaction, then drive tready
    always @(posedge clk)
    begin
        qpd_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (drive_reports_due.size() == 0)
            begin
                $error("result with no expectation pending: tdata %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = drive_reports_due.pop_front();
                compare_field("position", want.position, m_axis_tdata[31:0]);
                compare_field("edge_count", want.edge_count, m_axis_tdata[63:32]);
                compare_field("dir_forward", 32'(want.dir_forward), 32'(m_axis_tdata[64]));
                compare_field("dir_reverse", 32'(want.dir_reverse), 32'(m_axis_tdata[65]));
                compare_field("duty_ticks", 32'(want.duty_ticks), 32'(m_axis_tdata[81:66]));
                compare_field("drive_percent", 32'(want.drive_percent),
                              32'(m_axis_tdata[89:82]));
                compare_field("duty_written", 32'(want.duty_written), 32'(m_axis_tuser));
            end
        end
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin
        qpd_pkg::result_t r;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        enc_phase     = '0;
        pos_acc       = '0;
        edge_total    = '0;
        drive_on      = 1'b0;
        lift_pct      = qpd_pkg::MIN_DUTY_RESET;
        period_ticks  = qpd_pkg::PERIOD_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, no idling
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].load_cfg)
            begin
                s_axis_tvalid <= 1'b0;
                wait_reports_done();
                load_registers(DIRECTED[i].cfg.drive_enable, DIRECTED[i].cfg.min_duty,
                               DIRECTED[i].cfg.period);
            end
            push_item(DIRECTED[i].op, DIRECTED[i].levels, DIRECTED[i].target);
            r = advance_encoder(DIRECTED[i].op, DIRECTED[i].levels, DIRECTED[i].target);
            if (DIRECTED[i].typed)
                r = DIRECTED[i].want;
            drive_reports_due.push_back(r);
        end
        s_axis_tvalid <= 1'b0;
        wait_reports_done();

        // Random phases: idle and stall mix and register settings vary per phase
        run_phase(0, 0, 1'b1, 7'd20, 16'd5000, 60);
        run_phase(52, 0, 1'b1, 7'd0, 16'd65535, -1);
        run_phase(0, 52, 1'b0, 7'd100, 16'd1, -1);
        run_phase(36, 36, 1'b1, 7'd127, 16'd0, -1);
        run_phase(0, 0, 1'b1, 7'($urandom_range(0, 127)), 16'($urandom), 120);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && drive_reports_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
